@@ rtl/core/rotne_prager_pair_block_unit_assert.svh @@
// Assertion macros for the pair block; clk and rst_n come from the using module.
`ifndef ROTNE_PRAGER_PAIR_BLOCK_UNIT_ASSERT_SVH
`define ROTNE_PRAGER_PAIR_BLOCK_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RPP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RPP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rpp_pkg.sv @@
`default_nettype none

package rpp_pkg;

  localparam int DATA_W   = 32;
  localparam int RAD_W    = 31;
  localparam int DIFF_W   = 33;
  localparam int SQ_W     = 66;
  localparam int ROOT_W   = 33;
  localparam int REM_W    = 36;
  localparam int SQ_STG   = 33;
  localparam int DIV_STG  = 47;
  localparam int DIV_N_W  = 64;
  localparam int DSH_W    = DIV_N_W + DIV_STG;
  localparam int U_W      = 31;
  localparam int CAP_W    = 62;
  localparam int AX_W     = 49;
  localparam int NUM_DIV  = 4;

  localparam logic [CAP_W-1:0]  SAT_CAP = {1'b1, {(CAP_W-1){1'b0}}};
  localparam logic [31:0]       ONE_Q30 = 32'h4000_0000;
  localparam logic [RAD_W-1:0]  RADIUS_RST = 31'd65536;
  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] MIN64 = -64'sd2147483648;

  // Divider lanes.
  localparam int DV_UX = 0;
  localparam int DV_UY = 1;
  localparam int DV_GA = 2;
  localparam int DV_Q  = 3;

  typedef struct packed {
    logic sxn;
    logic syn;
    logic same;
    logic zero;
  } flags_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > MAX64) return SAT_MAX;
    else if (v < MIN64) return SAT_MIN;
    else return v[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rpp_in_if.sv @@
`default_nettype none

interface rpp_in_if;
  import rpp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] first_x;
  logic signed [DATA_W-1:0] first_y;
  logic signed [DATA_W-1:0] second_x;
  logic signed [DATA_W-1:0] second_y;
  logic                     same_particle;

  modport source (output valid, first_x, first_y, second_x, second_y, same_particle,
                  input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, same_particle,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/rpp_out_if.sv @@
`default_nettype none

interface rpp_out_if;
  import rpp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] entry_xx;
  logic signed [DATA_W-1:0] entry_xy;
  logic signed [DATA_W-1:0] entry_yy;
  logic                     coincident;

  modport source (output valid, entry_xx, entry_xy, entry_yy, coincident, input ready);
  modport sink   (input valid, entry_xx, entry_xy, entry_yy, coincident, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rotne_prager_pair_block_unit.sv @@
`default_nettype none

// Rotne-Prager 2x2 pair block, signed Q16.16 in and out. One pair enters per
// cycle whenever the pipeline advances. Stages A to C form the squared
// distance, a pipeline takes its integer square root one result bit per
// stage, four restoring dividers divide by the distance one quotient bit per
// stage, split multiplies in M1..M6 build the terms and a last stage saturates
// into the output register. The whole pipeline advances whenever the output
// word is empty or being taken, so in_ch.ready follows out_ch.ready; a stall
// freezes every stage and loses nothing. The radius register resets to 1.0 and
// may only be written while no pair is in flight.

`include "rotne_prager_pair_block_unit_assert.svh"

module rotne_prager_pair_block_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rpp_pkg::RAD_W-1:0] cfg_wr_data,
  rpp_in_if.sink                    in_ch,
  rpp_out_if.source                 out_ch
);
  import rpp_pkg::*;

  // ---------------------------------------------------------------- control
  logic             en;
  logic             out_vld_r;
  logic [RAD_W-1:0] radius_r;

  // Advance everything when the output word is free or leaving.
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // ------------------------------------------------ stage A: separations
  logic              sa_vld_r;
  logic [DIFF_W-1:0] sa_sxm_r, sa_sym_r;
  flags_t            sa_fl_r;
  logic [DIFF_W-1:0] sx, sy;

  always_comb begin
    sx = {in_ch.first_x[DATA_W-1], in_ch.first_x} - {in_ch.second_x[DATA_W-1], in_ch.second_x};
    sy = {in_ch.first_y[DATA_W-1], in_ch.first_y} - {in_ch.second_y[DATA_W-1], in_ch.second_y};
  end

  // ------------------------------------------------ stage B/C: squares, sum
  logic              sb_vld_r, sc_vld_r;
  logic [SQ_W-1:0]   sb_sqx_r, sb_sqy_r, sc_rad_r;
  logic [DIFF_W-1:0] sb_sxm_r, sb_sym_r, sc_sxm_r, sc_sym_r;
  flags_t            sb_fl_r, sc_fl_r;

  // ------------------------------------------------ square root pipeline
  logic              sq_vld_r  [SQ_STG];
  logic [SQ_W-1:0]   sq_rad_r  [SQ_STG];
  logic [REM_W-1:0]  sq_rem_r  [SQ_STG];
  logic [ROOT_W-1:0] sq_root_r [SQ_STG];
  logic [DIFF_W-1:0] sq_sxm_r  [SQ_STG];
  logic [DIFF_W-1:0] sq_sym_r  [SQ_STG];
  flags_t            sq_fl_r   [SQ_STG];
  logic              sq_vld_nxt  [SQ_STG];
  logic [SQ_W-1:0]   sq_rad_nxt  [SQ_STG];
  logic [REM_W-1:0]  sq_rem_nxt  [SQ_STG];
  logic [ROOT_W-1:0] sq_root_nxt [SQ_STG];
  logic [DIFF_W-1:0] sq_sxm_nxt  [SQ_STG];
  logic [DIFF_W-1:0] sq_sym_nxt  [SQ_STG];
  flags_t            sq_fl_nxt   [SQ_STG];

  // One root bit per stage: bring down two radicand bits, try 4*root+1.
  always_comb begin
    logic [SQ_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [REM_W+1:0]  rem2;
    logic [REM_W+1:0]  trial;
    for (int i = 0; i < SQ_STG; i++) begin
      if (i == 0) begin
        sq_vld_nxt[i] = sc_vld_r;
        sq_sxm_nxt[i] = sc_sxm_r;
        sq_sym_nxt[i] = sc_sym_r;
        sq_fl_nxt[i]  = sc_fl_r;
        rad  = sc_rad_r;
        rem  = '0;
        root = '0;
      end else begin
        sq_vld_nxt[i] = sq_vld_r[i-1];
        sq_sxm_nxt[i] = sq_sxm_r[i-1];
        sq_sym_nxt[i] = sq_sym_r[i-1];
        sq_fl_nxt[i]  = sq_fl_r[i-1];
        rad  = sq_rad_r[i-1];
        rem  = sq_rem_r[i-1];
        root = sq_root_r[i-1];
      end
      rem2  = {rem, rad[SQ_W-1 -: 2]};
      trial = (REM_W+2)'({root, 2'b01});
      sq_rad_nxt[i] = {rad[SQ_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        sq_rem_nxt[i]  = REM_W'(rem2 - trial);
        sq_root_nxt[i] = {root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_nxt[i]  = REM_W'(rem2);
        sq_root_nxt[i] = {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // ------------------------------------------------ divider pipeline
  logic                 dv_vld_r [DIV_STG];
  logic [ROOT_W-1:0]    dv_d_r   [DIV_STG];
  logic [DIV_N_W-1:0]   dv_rem_r [DIV_STG][NUM_DIV];
  logic [DIV_STG-1:0]   dv_quo_r [DIV_STG][NUM_DIV];
  flags_t               dv_fl_r  [DIV_STG];
  logic                 dv_vld_nxt [DIV_STG];
  logic [ROOT_W-1:0]    dv_d_nxt   [DIV_STG];
  logic [DIV_N_W-1:0]   dv_rem_nxt [DIV_STG][NUM_DIV];
  logic [DIV_STG-1:0]   dv_quo_nxt [DIV_STG][NUM_DIV];
  flags_t               dv_fl_nxt  [DIV_STG];
  logic [DIV_N_W-1:0]   dv_init [NUM_DIV];
  logic [RAD_W-1:0]     gq;

  // Numerators: |sx|*2^30, |sy|*2^30, floor(3a/4)*2^16, a*2^16.
  always_comb begin
    gq = RAD_W'(({2'b00, radius_r} + {1'b0, radius_r, 1'b0}) >> 2);
    dv_init[DV_UX] = DIV_N_W'(sq_sxm_r[SQ_STG-1]) << 30;
    dv_init[DV_UY] = DIV_N_W'(sq_sym_r[SQ_STG-1]) << 30;
    dv_init[DV_GA] = DIV_N_W'(gq) << 16;
    dv_init[DV_Q]  = DIV_N_W'(radius_r) << 16;
  end

  // Stage i decides quotient bit DIV_STG-1-i of all four lanes.
  always_comb begin
    logic [DIV_N_W-1:0] rem;
    logic [DIV_STG-1:0] quo;
    logic [ROOT_W-1:0]  dvs;
    logic [DSH_W-1:0]   dsh;
    for (int i = 0; i < DIV_STG; i++) begin
      if (i == 0) begin
        dv_vld_nxt[i] = sq_vld_r[SQ_STG-1];
        dv_fl_nxt[i]  = sq_fl_r[SQ_STG-1];
        dvs           = sq_root_r[SQ_STG-1];
      end else begin
        dv_vld_nxt[i] = dv_vld_r[i-1];
        dv_fl_nxt[i]  = dv_fl_r[i-1];
        dvs           = dv_d_r[i-1];
      end
      dv_d_nxt[i] = dvs;
      dsh = DSH_W'(dvs) << (DIV_STG - 1 - i);
      for (int j = 0; j < NUM_DIV; j++) begin
        if (i == 0) begin
          rem = dv_init[j];
          quo = '0;
        end else begin
          rem = dv_rem_r[i-1][j];
          quo = dv_quo_r[i-1][j];
        end
        if (DSH_W'(rem) >= dsh) begin
          dv_rem_nxt[i][j] = rem - DIV_N_W'(dsh);
          dv_quo_nxt[i][j] = {quo[DIV_STG-2:0], 1'b1};
        end else begin
          dv_rem_nxt[i][j] = rem;
          dv_quo_nxt[i][j] = {quo[DIV_STG-2:0], 1'b0};
        end
      end
    end
  end

  // ------------------------------------------------ term stages M1..M6
  localparam int L = DIV_STG - 1;

  logic [U_W-1:0]     uxm, uym;
  logic [DIV_STG-1:0] dq_ga, dq_q;
  assign uxm   = dv_quo_r[L][DV_UX][U_W-1:0];
  assign uym   = dv_quo_r[L][DV_UY][U_W-1:0];
  assign dq_ga = dv_quo_r[L][DV_GA];
  assign dq_q  = dv_quo_r[L][DV_Q];

  // M1: squares and product of the unit components, partials of q*q.
  logic               m1_vld_r;
  flags_t             m1_fl_r;
  logic [2*U_W-1:0]   m1_ux2p_r, m1_uy2p_r, m1_uvp_r;
  logic [45:0]        m1_qhh_r;
  logic [46:0]        m1_qhl_r;
  logic [47:0]        m1_qll_r;
  logic [DIV_STG-1:0] m1_ga_r, m1_q_r;

  // M2: q2, diagonal coefficients, |ux*uy|.
  logic               m2_vld_r;
  flags_t             m2_fl_r;
  logic [31:0]        m2_c1x_r, m2_c1y_r, m2_c2xm_r, m2_c2ym_r;
  logic               m2_c2xn_r, m2_c2yn_r;
  logic [U_W-1:0]     m2_uvm_r;
  logic [CAP_W-1:0]   m2_q2_r;
  logic [DIV_STG-1:0] m2_ga_r, m2_q_r;
  logic [93:0]        q2_full;
  logic [CAP_W-1:0]   q2_v;
  logic [U_W-1:0]     ux2, uy2;
  logic [33:0]        c2x, c2y;

  always_comb begin
    q2_full = (94'(m1_qhh_r) << 48) + (94'(m1_qhl_r) << 25) + 94'(m1_qll_r);
    q2_v    = ((q2_full >> 16) > 94'(SAT_CAP)) ? SAT_CAP : q2_full[CAP_W+15:16];
    ux2     = m1_ux2p_r[2*U_W-2:30];
    uy2     = m1_uy2p_r[2*U_W-2:30];
    c2x     = 34'(ONE_Q30) - (34'(ux2) + (34'(ux2) << 1));
    c2y     = 34'(ONE_Q30) - (34'(uy2) + (34'(uy2) << 1));
  end

  // M3: partials of q2*q and ga*c1.
  logic               m3_vld_r;
  flags_t             m3_fl_r;
  logic [53:0]        m3_phh_r, m3_plh_r;
  logic [54:0]        m3_phl_r, m3_pll_r;
  logic [54:0]        m3_axh_r, m3_ayh_r;
  logic [55:0]        m3_axl_r, m3_ayl_r;
  logic [31:0]        m3_c2xm_r, m3_c2ym_r;
  logic               m3_c2xn_r, m3_c2yn_r;
  logic [U_W-1:0]     m3_uvm_r;
  logic [DIV_STG-1:0] m3_ga_r;

  // M4: q3 and B, A-terms.
  logic               m4_vld_r;
  flags_t             m4_fl_r;
  logic [CAP_W-2:0]   m4_gb_r;
  logic [AX_W-1:0]    m4_ax_r, m4_ay_r;
  logic [31:0]        m4_c2xm_r, m4_c2ym_r;
  logic               m4_c2xn_r, m4_c2yn_r;
  logic [U_W-1:0]     m4_uvm_r;
  logic [DIV_STG-1:0] m4_ga_r;
  logic [109:0]       q3_full;
  logic [CAP_W-1:0]   q3_v;
  logic [79:0]        ax_full, ay_full;

  always_comb begin
    q3_full = (110'(m3_phh_r) << 55) + (110'(m3_phl_r) << 31)
            + (110'(m3_plh_r) << 24) + 110'(m3_pll_r);
    q3_v    = ((q3_full >> 16) > 110'(SAT_CAP)) ? SAT_CAP : q3_full[CAP_W+15:16];
    ax_full = (80'(m3_axh_r) << 24) + 80'(m3_axl_r);
    ay_full = (80'(m3_ayh_r) << 24) + 80'(m3_ayl_r);
  end

  // M5: t = A - 3B clamped, partials of B*c2.
  logic               m5_vld_r;
  flags_t             m5_fl_r;
  logic [CAP_W-1:0]   m5_tm_r;
  logic               m5_tn_r;
  logic [61:0]        m5_bxh_r, m5_byh_r;
  logic [62:0]        m5_bxl_r, m5_byl_r;
  logic               m5_c2xn_r, m5_c2yn_r;
  logic [AX_W-1:0]    m5_ax_r, m5_ay_r;
  logic [U_W-1:0]     m5_uvm_r;
  logic [63:0]        tv;
  logic [63:0]        tv_mag;

  always_comb begin
    tv     = 64'(m4_ga_r) - (64'(m4_gb_r) + (64'(m4_gb_r) << 1));
    tv_mag = tv[63] ? (~tv + 64'd1) : tv;
  end

  // M6: B-terms, partials of t*uv.
  logic               m6_vld_r;
  flags_t             m6_fl_r;
  logic signed [63:0] m6_bx_r, m6_by_r;
  logic [AX_W-1:0]    m6_ax_r, m6_ay_r;
  logic [61:0]        m6_ph_r, m6_pl_r;
  logic               m6_xyn_r;
  logic [93:0]        bx_full, by_full;
  logic [CAP_W-1:0]   bxm, bym;

  always_comb begin
    bx_full = (94'(m5_bxh_r) << 31) + 94'(m5_bxl_r);
    by_full = (94'(m5_byh_r) << 31) + 94'(m5_byl_r);
    bxm     = bx_full[CAP_W+29:30];
    bym     = by_full[CAP_W+29:30];
  end

  // Output stage: sums, saturation, special cases.
  logic signed [DATA_W-1:0] out_xx_r, out_xy_r, out_yy_r;
  logic                     out_coinc_r;
  logic [93:0]              xy_full;
  logic [CAP_W-1:0]         xym;
  logic signed [63:0]       xy_v, xx_v, yy_v;

  always_comb begin
    xy_full = (94'(m6_ph_r) << 31) + 94'(m6_pl_r);
    xym     = xy_full[CAP_W+29:30];
    xy_v    = m6_xyn_r ? $signed(-64'(xym)) : $signed(64'(xym));
    xx_v    = $signed(64'(m6_ax_r)) + m6_bx_r;
    yy_v    = $signed(64'(m6_ay_r)) + m6_by_r;
  end

  // ------------------------------------------------ valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r  <= 1'b0;
      sb_vld_r  <= 1'b0;
      sc_vld_r  <= 1'b0;
      for (int i = 0; i < SQ_STG; i++) sq_vld_r[i] <= 1'b0;
      for (int i = 0; i < DIV_STG; i++) dv_vld_r[i] <= 1'b0;
      m1_vld_r  <= 1'b0;
      m2_vld_r  <= 1'b0;
      m3_vld_r  <= 1'b0;
      m4_vld_r  <= 1'b0;
      m5_vld_r  <= 1'b0;
      m6_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      sa_vld_r  <= in_ch.valid;
      sb_vld_r  <= sa_vld_r;
      sc_vld_r  <= sb_vld_r;
      for (int i = 0; i < SQ_STG; i++) sq_vld_r[i] <= sq_vld_nxt[i];
      for (int i = 0; i < DIV_STG; i++) dv_vld_r[i] <= dv_vld_nxt[i];
      m1_vld_r  <= dv_vld_r[L];
      m2_vld_r  <= m1_vld_r;
      m3_vld_r  <= m2_vld_r;
      m4_vld_r  <= m3_vld_r;
      m5_vld_r  <= m4_vld_r;
      m6_vld_r  <= m5_vld_r;
      out_vld_r <= m6_vld_r;
    end
  end

  // ------------------------------------------------ payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      // Separation magnitudes and signs.
      sa_sxm_r     <= sx[DIFF_W-1] ? (~sx + 1'b1) : sx;
      sa_sym_r     <= sy[DIFF_W-1] ? (~sy + 1'b1) : sy;
      sa_fl_r.sxn  <= sx[DIFF_W-1];
      sa_fl_r.syn  <= sy[DIFF_W-1];
      sa_fl_r.same <= in_ch.same_particle;
      sa_fl_r.zero <= (sx == '0) && (sy == '0);

      sb_sqx_r <= SQ_W'(sa_sxm_r) * SQ_W'(sa_sxm_r);
      sb_sqy_r <= SQ_W'(sa_sym_r) * SQ_W'(sa_sym_r);
      sb_sxm_r <= sa_sxm_r;
      sb_sym_r <= sa_sym_r;
      sb_fl_r  <= sa_fl_r;

      sc_rad_r <= sb_sqx_r + sb_sqy_r;
      sc_sxm_r <= sb_sxm_r;
      sc_sym_r <= sb_sym_r;
      sc_fl_r  <= sb_fl_r;

      for (int i = 0; i < SQ_STG; i++) begin
        sq_rad_r[i]  <= sq_rad_nxt[i];
        sq_rem_r[i]  <= sq_rem_nxt[i];
        sq_root_r[i] <= sq_root_nxt[i];
        sq_sxm_r[i]  <= sq_sxm_nxt[i];
        sq_sym_r[i]  <= sq_sym_nxt[i];
        sq_fl_r[i]   <= sq_fl_nxt[i];
      end

      for (int i = 0; i < DIV_STG; i++) begin
        dv_d_r[i]  <= dv_d_nxt[i];
        dv_fl_r[i] <= dv_fl_nxt[i];
        for (int j = 0; j < NUM_DIV; j++) begin
          dv_rem_r[i][j] <= dv_rem_nxt[i][j];
          dv_quo_r[i][j] <= dv_quo_nxt[i][j];
        end
      end

      // M1
      m1_fl_r   <= dv_fl_r[L];
      m1_ux2p_r <= (2*U_W)'(uxm) * (2*U_W)'(uxm);
      m1_uy2p_r <= (2*U_W)'(uym) * (2*U_W)'(uym);
      m1_uvp_r  <= (2*U_W)'(uxm) * (2*U_W)'(uym);
      m1_qhh_r  <= 46'(dq_q[46:24]) * 46'(dq_q[46:24]);
      m1_qhl_r  <= 47'(dq_q[46:24]) * 47'(dq_q[23:0]);
      m1_qll_r  <= 48'(dq_q[23:0]) * 48'(dq_q[23:0]);
      m1_ga_r   <= dq_ga;
      m1_q_r    <= dq_q;

      // M2
      m2_fl_r   <= m1_fl_r;
      m2_c1x_r  <= ONE_Q30 + 32'(ux2);
      m2_c1y_r  <= ONE_Q30 + 32'(uy2);
      m2_c2xn_r <= c2x[33];
      m2_c2yn_r <= c2y[33];
      m2_c2xm_r <= c2x[33] ? 32'(~c2x + 34'd1) : c2x[31:0];
      m2_c2ym_r <= c2y[33] ? 32'(~c2y + 34'd1) : c2y[31:0];
      m2_uvm_r  <= m1_uvp_r[2*U_W-2:30];
      m2_q2_r   <= q2_v;
      m2_ga_r   <= m1_ga_r;
      m2_q_r    <= m1_q_r;

      // M3
      m3_fl_r   <= m2_fl_r;
      m3_phh_r  <= 54'(m2_q2_r[61:31]) * 54'(m2_q_r[46:24]);
      m3_phl_r  <= 55'(m2_q2_r[61:31]) * 55'(m2_q_r[23:0]);
      m3_plh_r  <= 54'(m2_q2_r[30:0]) * 54'(m2_q_r[46:24]);
      m3_pll_r  <= 55'(m2_q2_r[30:0]) * 55'(m2_q_r[23:0]);
      m3_axh_r  <= 55'(m2_ga_r[46:24]) * 55'(m2_c1x_r);
      m3_axl_r  <= 56'(m2_ga_r[23:0]) * 56'(m2_c1x_r);
      m3_ayh_r  <= 55'(m2_ga_r[46:24]) * 55'(m2_c1y_r);
      m3_ayl_r  <= 56'(m2_ga_r[23:0]) * 56'(m2_c1y_r);
      m3_c2xm_r <= m2_c2xm_r;
      m3_c2ym_r <= m2_c2ym_r;
      m3_c2xn_r <= m2_c2xn_r;
      m3_c2yn_r <= m2_c2yn_r;
      m3_uvm_r  <= m2_uvm_r;
      m3_ga_r   <= m2_ga_r;

      // M4
      m4_fl_r   <= m3_fl_r;
      m4_gb_r   <= q3_v[CAP_W-1:1];
      m4_ax_r   <= ax_full[AX_W+29:30];
      m4_ay_r   <= ay_full[AX_W+29:30];
      m4_c2xm_r <= m3_c2xm_r;
      m4_c2ym_r <= m3_c2ym_r;
      m4_c2xn_r <= m3_c2xn_r;
      m4_c2yn_r <= m3_c2yn_r;
      m4_uvm_r  <= m3_uvm_r;
      m4_ga_r   <= m3_ga_r;

      // M5: clamp A - 3B below at -2^61; it never reaches +2^61.
      m5_fl_r   <= m4_fl_r;
      if (tv[63] && (tv_mag > 64'(SAT_CAP))) begin
        m5_tm_r <= SAT_CAP;
      end else begin
        m5_tm_r <= tv_mag[CAP_W-1:0];
      end
      m5_tn_r   <= tv[63];
      m5_bxh_r  <= 62'(m4_gb_r[60:31]) * 62'(m4_c2xm_r);
      m5_bxl_r  <= 63'(m4_gb_r[30:0]) * 63'(m4_c2xm_r);
      m5_byh_r  <= 62'(m4_gb_r[60:31]) * 62'(m4_c2ym_r);
      m5_byl_r  <= 63'(m4_gb_r[30:0]) * 63'(m4_c2ym_r);
      m5_c2xn_r <= m4_c2xn_r;
      m5_c2yn_r <= m4_c2yn_r;
      m5_ax_r   <= m4_ax_r;
      m5_ay_r   <= m4_ay_r;
      m5_uvm_r  <= m4_uvm_r;

      // M6
      m6_fl_r  <= m5_fl_r;
      m6_bx_r  <= m5_c2xn_r ? $signed(-64'(bxm)) : $signed(64'(bxm));
      m6_by_r  <= m5_c2yn_r ? $signed(-64'(bym)) : $signed(64'(bym));
      m6_ax_r  <= m5_ax_r;
      m6_ay_r  <= m5_ay_r;
      m6_ph_r  <= 62'(m5_tm_r[61:31]) * 62'(m5_uvm_r);
      m6_pl_r  <= 62'(m5_tm_r[30:0]) * 62'(m5_uvm_r);
      m6_xyn_r <= m5_tn_r ^ m5_fl_r.sxn ^ m5_fl_r.syn;

      // Output word: same particle wins over coincident.
      if (m6_fl_r.same) begin
        out_xx_r    <= ONE_Q16;
        out_xy_r    <= '0;
        out_yy_r    <= ONE_Q16;
        out_coinc_r <= 1'b0;
      end else if (m6_fl_r.zero) begin
        out_xx_r    <= SAT_MAX;
        out_xy_r    <= '0;
        out_yy_r    <= SAT_MAX;
        out_coinc_r <= 1'b1;
      end else begin
        out_xx_r    <= sat32(xx_v);
        out_xy_r    <= sat32(xy_v);
        out_yy_r    <= sat32(yy_v);
        out_coinc_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.entry_xx   = out_xx_r;
  assign out_ch.entry_xy   = out_xy_r;
  assign out_ch.entry_yy   = out_yy_r;
  assign out_ch.coincident = out_coinc_r;

  // ------------------------------------------------ assertions
  `RPP_ASSERT_IMP(a_coinc_saturates, out_vld_r && out_coinc_r, (out_xx_r == SAT_MAX) && (out_yy_r == SAT_MAX) && (out_xy_r == '0), "coincident word without saturated entries")
  `RPP_ASSERT_NXT(a_stall_freezes, !en, $stable(dv_vld_r[L]) && $stable(m6_vld_r) && $stable(sa_vld_r), "pipeline moved during a stall")
  `RPP_ASSERT_NXT(a_last_stage_lands, en && m6_vld_r, out_vld_r, "result lost between last stage and output")

endmodule

`default_nettype wire
